// ===== rtl/stop_and_wait_frame_receiver_assert.svh =====
// ----------------------------------------------------------------------------
// stop-and-wait frame receiver assertion macros
// shared concurrent checks, clocked on the rising edge, off during reset
// ----------------------------------------------------------------------------
`ifndef STOP_AND_WAIT_FRAME_RECEIVER_ASSERT_SVH
`define STOP_AND_WAIT_FRAME_RECEIVER_ASSERT_SVH

// same-cycle implication
`define SWFR_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("swfr assertion failed");

// next-cycle implication
`define SWFR_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("swfr assertion failed");

`endif

// ===== rtl/swfr_pkg.sv =====
// ----------------------------------------------------------------------------
// swfr_pkg
// types, codes and helper functions of the stop-and-wait frame receiver
// ----------------------------------------------------------------------------
package swfr_pkg;

    // frame header flag and reply codes
    localparam logic [7:0] FLAG_LAST = 8'h08;
    localparam logic [1:0] CODE_ACK  = 2'd1;
    localparam logic [1:0] CODE_NAK  = 2'd2;

    // result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // frame verdicts
    typedef enum logic [1:0] {
        VERDICT_ACCEPT = 2'd0,
        VERDICT_DUP    = 2'd1,
        VERDICT_BAD    = 2'd2
    } verdict_t;

    // one result transaction, less the message byte count
    typedef struct packed {
        logic       kind;
        logic [7:0] payload;
        verdict_t   verdict;
        logic [7:0] check;
        logic [1:0] rtype;
        logic [7:0] seq;
        logic       done;
    } result_t;

    // 8-bit add with end-around carry
    function automatic logic [7:0] fold_add(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s[8]) begin
            fold_add = s[7:0] + 8'd1;
        end else begin
            fold_add = s[7:0];
        end
    endfunction

endpackage

// ===== rtl/swfr_frame.sv =====
// ----------------------------------------------------------------------------
// swfr_frame
// per-byte frame parser: checksum, header capture, payload pass, verdict
// ----------------------------------------------------------------------------
module swfr_frame import swfr_pkg::*; #(
    parameter int PAYLOAD_BYTES = 509,
    parameter int COUNT_WIDTH   = 24
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   step,
    input  logic [7:0]             data_byte,
    input  logic                   frame_end,
    output logic                   has_result,
    output result_t                result,
    output logic [COUNT_WIDTH-1:0] message_bytes
);

    localparam int FRAME_BYTES = PAYLOAD_BYTES + 4;
    localparam int POS_W       = $clog2(FRAME_BYTES + 1);
    localparam int CMP_W       = (POS_W > 9) ? POS_W : 9;
    localparam int SUM_W       = ((COUNT_WIDTH > POS_W) ? COUNT_WIDTH : POS_W) + 1;

    logic [POS_W-1:0]       pos_reg, pos_next;
    logic [7:0]             sum_reg, sum_next;
    logic [7:0]             flag_reg, flag_next;
    logic [7:0]             seq_reg, seq_next;
    logic [7:0]             len_reg, len_next;
    logic [7:0]             prev_reg, prev_next;
    logic [COUNT_WIDTH-1:0] acc_reg, acc_next;
    logic [POS_W-1:0]       fpc_reg, fpc_next;

    logic                   in_range;
    logic [7:0]             sum_upd, flag_upd, seq_upd, len_upd;
    logic [CMP_W-1:0]       pos_ext;
    logic                   is_payload;
    logic [SUM_W-1:0]       acc_sum;
    logic [COUNT_WIDTH-1:0] acc_sat;
    logic                   sum_ok, is_dup;
    logic [1:0]             code;

    // byte update: fold into sum, capture header fields, mark payload bytes
    always_comb begin
        in_range = pos_reg < POS_W'(FRAME_BYTES);
        pos_ext  = CMP_W'(pos_reg);
        sum_upd  = in_range ? fold_add(sum_reg, data_byte) : sum_reg;
        flag_upd = (in_range && pos_reg == POS_W'(1)) ? data_byte : flag_reg;
        seq_upd  = (in_range && pos_reg == POS_W'(2)) ? data_byte : seq_reg;
        len_upd  = (in_range && pos_reg == POS_W'(3)) ? data_byte : len_reg;
        if (flag_upd == FLAG_LAST) begin
            is_payload = in_range && pos_ext >= CMP_W'(4)
                         && pos_ext < (CMP_W'(len_upd) + CMP_W'(4));
        end else begin
            is_payload = in_range && pos_ext >= CMP_W'(3)
                         && pos_ext < CMP_W'(PAYLOAD_BYTES + 3);
        end
    end

    // verdict terms and saturating message count
    always_comb begin
        sum_ok  = sum_upd == 8'hFF;
        is_dup  = seq_upd == prev_reg;
        code    = sum_ok ? CODE_ACK : CODE_NAK;
        acc_sum = SUM_W'(acc_reg) + SUM_W'(fpc_reg);
        if (acc_sum[SUM_W-1:COUNT_WIDTH] != '0) begin
            acc_sat = '1;
        end else begin
            acc_sat = acc_sum[COUNT_WIDTH-1:0];
        end
    end

    // result fields and next state
    always_comb begin
        pos_next      = pos_reg;
        sum_next      = sum_reg;
        flag_next     = flag_reg;
        seq_next      = seq_reg;
        len_next      = len_reg;
        prev_next     = prev_reg;
        acc_next      = acc_reg;
        fpc_next      = fpc_reg;
        has_result    = frame_end || is_payload;
        result        = '0;
        message_bytes = '0;
        if (frame_end) begin
            result.kind  = KIND_VERDICT;
            result.check = ~fold_add({6'd0, code}, seq_upd);
            result.rtype = code;
            result.seq   = seq_upd;
            message_bytes = acc_reg;
            if (!sum_ok) begin
                result.verdict = VERDICT_BAD;
            end else if (is_dup) begin
                result.verdict = VERDICT_DUP;
            end else begin
                result.verdict = VERDICT_ACCEPT;
                message_bytes  = acc_sat;
                prev_next      = seq_upd;
                if (flag_upd == FLAG_LAST) begin
                    result.done = 1'b1;
                    acc_next    = '0;
                end else begin
                    acc_next    = acc_sat;
                end
            end
            pos_next  = '0;
            sum_next  = '0;
            flag_next = '0;
            seq_next  = '0;
            len_next  = '0;
            fpc_next  = '0;
        end else begin
            result.kind    = KIND_PAYLOAD;
            result.payload = is_payload ? data_byte : 8'd0;
            sum_next  = sum_upd;
            flag_next = flag_upd;
            seq_next  = seq_upd;
            len_next  = len_upd;
            if (in_range) begin
                pos_next = pos_reg + POS_W'(1);
            end
            if (is_payload) begin
                fpc_next = fpc_reg + POS_W'(1);
            end
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            sum_reg  <= '0;
            flag_reg <= '0;
            seq_reg  <= '0;
            len_reg  <= '0;
            prev_reg <= 8'hFF;
            acc_reg  <= '0;
            fpc_reg  <= '0;
        end else if (step) begin
            pos_reg  <= pos_next;
            sum_reg  <= sum_next;
            flag_reg <= flag_next;
            seq_reg  <= seq_next;
            len_reg  <= len_next;
            prev_reg <= prev_next;
            acc_reg  <= acc_next;
            fpc_reg  <= fpc_next;
        end
    end

endmodule

// ===== rtl/stop_and_wait_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// stop_and_wait_frame_receiver
// byte-wide datagram receiver with checksum check and ack/nak verdicts
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  s_        in         data_byte, frame_end
//  m_        out        result_kind, payload_byte, verdict, reply fields, count
//
//  one byte per cycle sustained unless a result waits on a stalled output; a byte
//  passes an input register, parse/checksum logic and lands in the output register
//  synchronous active-low reset clears parser state, sequence memory to 0xFF
//  a stalled output holds the parser only when the pending byte makes a result
//  bytes that make no result keep flowing while the output waits
`include "stop_and_wait_frame_receiver_assert.svh"

module stop_and_wait_frame_receiver import swfr_pkg::*; #(
    parameter int PAYLOAD_BYTES = 509,
    parameter int COUNT_WIDTH   = 24
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [7:0]             s_data_byte,
    input  logic                   s_frame_end,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_result_kind,
    output logic [7:0]             m_payload_byte,
    output logic [1:0]             m_verdict,
    output logic [7:0]             m_reply_check,
    output logic [1:0]             m_reply_type,
    output logic [7:0]             m_reply_seq,
    output logic                   m_message_done,
    output logic [COUNT_WIDTH-1:0] m_message_bytes
);

    logic                   in_valid_reg, in_valid_next;
    logic [7:0]             in_data_reg;
    logic                   in_end_reg;
    logic                   out_valid_reg, out_valid_next;
    result_t                out_res_reg;
    logic [COUNT_WIDTH-1:0] out_bytes_reg;

    logic                   has_result;
    result_t                res;
    logic [COUNT_WIDTH-1:0] res_bytes;
    logic                   out_free, advance, load_out;

    // handshake and stage control
    always_comb begin
        out_free       = !out_valid_reg || m_ready;
        advance        = in_valid_reg && (!has_result || out_free);
        load_out       = advance && has_result;
        s_ready        = !in_valid_reg || advance;
        in_valid_next  = (s_valid && s_ready) || (in_valid_reg && !advance);
        out_valid_next = load_out || (out_valid_reg && !m_ready);
    end

    // frame parser
    swfr_frame #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES),
        .COUNT_WIDTH   (COUNT_WIDTH)
    ) u_frame (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (advance),
        .data_byte     (in_data_reg),
        .frame_end     (in_end_reg),
        .has_result    (has_result),
        .result        (res),
        .message_bytes (res_bytes)
    );

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
        if (s_valid && s_ready) begin
            in_data_reg <= s_data_byte;
            in_end_reg  <= s_frame_end;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
        if (load_out) begin
            out_res_reg   <= res;
            out_bytes_reg <= res_bytes;
        end
    end

    // result ports
    assign m_valid         = out_valid_reg;
    assign m_result_kind   = out_res_reg.kind;
    assign m_payload_byte  = out_res_reg.payload;
    assign m_verdict       = out_res_reg.verdict;
    assign m_reply_check   = out_res_reg.check;
    assign m_reply_type    = out_res_reg.rtype;
    assign m_reply_seq     = out_res_reg.seq;
    assign m_message_done  = out_res_reg.done;
    assign m_message_bytes = out_bytes_reg;

    // nak exactly when the checksum failed
    `SWFR_ASSERT_IMP(a_nak_on_bad, aclk, aresetn,
        m_valid && m_result_kind == KIND_VERDICT,
        (m_verdict == VERDICT_BAD) == (m_reply_type == CODE_NAK))
    // message completion only on an accepted frame
    `SWFR_ASSERT_IMP(a_done_accepted, aclk, aresetn,
        m_valid && m_message_done,
        m_result_kind == KIND_VERDICT && m_verdict == VERDICT_ACCEPT)
    // a held byte is not dropped from the input register
    `SWFR_ASSERT_NXT(a_hold_input, aclk, aresetn,
        in_valid_reg && !advance,
        in_valid_reg && $stable(in_data_reg) && $stable(in_end_reg))
    // a new result only loads into a free output slot
    `SWFR_ASSERT_IMP(a_no_overwrite, aclk, aresetn,
        load_out,
        !out_valid_reg || m_ready)

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: stop-and-wait frame receiver testbench
// drives datagram bytes with random gaps, predicts passed payload bytes and
// frame verdicts with an in-bench parser, and checks every result transaction
// ----------------------------------------------------------------------------
module tb_top;
    import swfr_pkg::*;

    localparam int PAYLOAD_BYTES  = 509;
    localparam int COUNT_WIDTH    = 24;
    localparam int FRAME_LEN      = PAYLOAD_BYTES + 4;
    localparam int RANDOM_BYTES   = 1350;
    localparam int LONG_AFTER     = 500;
    localparam int HOLD_AT_RESULT = 300;
    localparam int HOLD_CYCLES    = 250;
    localparam int DRAIN_CYCLES   = 16;
    localparam int MAX_CYCLES     = 400000;

    typedef struct packed {
        logic [7:0] data;
        logic       fin;
    } rx_byte_t;

    typedef struct packed {
        result_t                fields;
        logic [COUNT_WIDTH-1:0] msg_bytes;
    } rx_output_t;

    logic                   aclk        = 1'b0;
    logic                   aresetn     = 1'b0;
    logic                   s_valid     = 1'b0;
    logic                   s_ready;
    logic [7:0]             s_data_byte = 8'h00;
    logic                   s_frame_end = 1'b0;
    logic                   m_valid;
    logic                   m_ready     = 1'b0;
    logic                   m_result_kind;
    logic [7:0]             m_payload_byte;
    logic [1:0]             m_verdict;
    logic [7:0]             m_reply_check;
    logic [1:0]             m_reply_type;
    logic [7:0]             m_reply_seq;
    logic                   m_message_done;
    logic [COUNT_WIDTH-1:0] m_message_bytes;

    stop_and_wait_frame_receiver #(
        .PAYLOAD_BYTES(PAYLOAD_BYTES),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_frame_end    (s_frame_end),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_kind  (m_result_kind),
        .m_payload_byte (m_payload_byte),
        .m_verdict      (m_verdict),
        .m_reply_check  (m_reply_check),
        .m_reply_type   (m_reply_type),
        .m_reply_seq    (m_reply_seq),
        .m_message_done (m_message_done),
        .m_message_bytes(m_message_bytes)
    );

    // pending datagram bytes and predicted output transactions
    rx_byte_t   datagram_q[$];
    rx_output_t rx_output_q[$];

    int errors         = 0;
    int bytes_total    = 0;
    int bytes_accepted = 0;
    int frames_sent    = 0;
    int results_seen   = 0;
    int payload_seen   = 0;
    int accept_seen    = 0;
    int dup_seen       = 0;
    int bad_seen       = 0;
    int cycles         = 0;
    int send_wait      = 0;
    int send_calm      = 0;
    int ready_wait     = 0;
    int ready_calm     = 0;

    // parser state mirrored by the bench
    logic [9:0]             pos_r;
    logic [7:0]             sum_r;
    logic [7:0]             flag_r;
    logic [7:0]             seq_r;
    logic [7:0]             len_r;
    logic [7:0]             prev_seq_r;
    logic [COUNT_WIDTH-1:0] msg_count_r;
    logic [9:0]             frame_pay_r;

    // clock
    initial begin
        forever #4 aclk = ~aclk;
    end

    // 8-bit ones' complement add
    function automatic logic [7:0] ones_add(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[7:0] + {7'd0, s[8]};
    endfunction

    // per-item wait, with occasional stretches of back-to-back items
    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            calm = $urandom_range(15, 50);
            return 0;
        end
        return $urandom_range(0, 8);
    endfunction

    task automatic clear_frame_state();
        pos_r       = '0;
        sum_r       = '0;
        flag_r      = '0;
        seq_r       = '0;
        len_r       = '0;
        frame_pay_r = '0;
    endtask

    // advance the parser by one accepted byte, queue what it should emit
    task automatic track_frame_byte(input logic [7:0] b, input logic fin);
        logic                 pass;
        logic [COUNT_WIDTH:0] total;
        logic [1:0]           code;
        rx_output_t           o;
        pass = 1'b0;
        o    = '0;
        if (pos_r < FRAME_LEN) begin
            sum_r = ones_add(sum_r, b);
            case (pos_r)
                10'd1: flag_r = b;
                10'd2: seq_r = b;
                10'd3: len_r = b;
                default: ;
            endcase
            if (flag_r == FLAG_LAST) begin
                pass = (pos_r >= 4) && (pos_r < 4 + len_r);
            end else begin
                pass = (pos_r >= 3) && (pos_r < PAYLOAD_BYTES + 3);
            end
            pos_r = pos_r + 10'd1;
        end
        if (!fin) begin
            if (pass) begin
                frame_pay_r          = frame_pay_r + 10'd1;
                o.fields.kind        = KIND_PAYLOAD;
                o.fields.payload     = b;
                rx_output_q.push_back(o);
            end
        end else begin
            o.fields.kind = KIND_VERDICT;
            if (sum_r != 8'hFF) begin
                o.fields.verdict = VERDICT_BAD;
                code             = CODE_NAK;
            end else if (seq_r == prev_seq_r) begin
                o.fields.verdict = VERDICT_DUP;
                code             = CODE_ACK;
            end else begin
                o.fields.verdict = VERDICT_ACCEPT;
                code             = CODE_ACK;
                prev_seq_r       = seq_r;
                total            = {1'b0, msg_count_r} + frame_pay_r;
                if (total > {1'b0, {COUNT_WIDTH{1'b1}}}) begin
                    total = {1'b0, {COUNT_WIDTH{1'b1}}};
                end
                msg_count_r      = total[COUNT_WIDTH-1:0];
                o.fields.done    = (flag_r == FLAG_LAST);
            end
            o.fields.check = ~ones_add({6'd0, code}, seq_r);
            o.fields.rtype = code;
            o.fields.seq   = seq_r;
            o.msg_bytes    = msg_count_r;
            if (o.fields.done) begin
                msg_count_r = '0;
            end
            rx_output_q.push_back(o);
            clear_frame_state();
        end
    endtask

    // checksum byte first, then the body; corrupt bends the checksum
    task automatic queue_datagram(input logic [7:0] body[$], input bit corrupt);
        logic [7:0] sum;
        logic [7:0] ck;
        int         lim;
        sum = 8'h00;
        lim = (body.size() < FRAME_LEN - 1) ? body.size() : FRAME_LEN - 1;
        for (int i = 0; i < lim; i++) begin
            sum = ones_add(sum, body[i]);
        end
        ck = ~sum;
        if (corrupt) begin
            ck = ck + 8'($urandom_range(1, 254));
        end
        datagram_q.push_back('{data: ck, fin: (body.size() == 0)});
        for (int i = 0; i < body.size(); i++) begin
            datagram_q.push_back('{data: body[i], fin: (i == body.size() - 1)});
        end
        frames_sent++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
            errors++;
        end
    endtask

    // input driver
    always @(posedge aclk) begin : drv_proc
        rx_byte_t nxt;
        if (!aresetn) begin
            s_valid   <= 1'b0;
            send_wait = 0;
        end else begin
            if (s_valid && s_ready) begin
                track_frame_byte(s_data_byte, s_frame_end);
                bytes_accepted++;
            end
            if (s_valid && !s_ready) begin
                // hold the offered byte until taken
            end else if (send_wait > 0) begin
                send_wait--;
                s_valid <= 1'b0;
            end else if (datagram_q.size() > 0) begin
                nxt         = datagram_q.pop_front();
                s_valid     <= 1'b1;
                s_data_byte <= nxt.data;
                s_frame_end <= nxt.fin;
                send_wait   = draw_wait(send_calm);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result monitor and ready generation
    always @(posedge aclk) begin : mon_proc
        rx_output_t want;
        int         pause;
        if (!aresetn) begin
            m_ready    <= 1'b0;
            ready_wait = 0;
        end else begin
            pause = ready_wait;
            if (m_valid && m_ready) begin
                if (rx_output_q.size() == 0) begin
                    $display("%0t: unexpected result transaction, kind %0d payload 0x%0h verdict %0d",
                             $time, m_result_kind, m_payload_byte, m_verdict);
                    errors++;
                end else begin
                    want = rx_output_q.pop_front();
                    compare_field("result_kind", want.fields.kind, m_result_kind);
                    compare_field("payload_byte", want.fields.payload, m_payload_byte);
                    compare_field("verdict", want.fields.verdict, m_verdict);
                    compare_field("reply_check", want.fields.check, m_reply_check);
                    compare_field("reply_type", want.fields.rtype, m_reply_type);
                    compare_field("reply_seq", want.fields.seq, m_reply_seq);
                    compare_field("message_done", want.fields.done, m_message_done);
                    compare_field("message_bytes", want.msg_bytes, m_message_bytes);
                end
                results_seen++;
                if (m_result_kind == KIND_PAYLOAD) begin
                    payload_seen++;
                end else if (m_verdict == VERDICT_ACCEPT) begin
                    accept_seen++;
                end else if (m_verdict == VERDICT_DUP) begin
                    dup_seen++;
                end else begin
                    bad_seen++;
                end
                // one long back-pressure stretch to fill the block
                if (results_seen == HOLD_AT_RESULT) begin
                    pause = HOLD_CYCLES;
                end else begin
                    pause = draw_wait(ready_calm);
                end
            end else if (pause > 0) begin
                pause--;
            end
            ready_wait = pause;
            m_ready    <= (pause == 0);
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycles++;
        if (cycles == MAX_CYCLES) begin
            $display("%0t: timeout with %0d of %0d bytes taken, %0d results outstanding",
                     $time, bytes_accepted, bytes_total, rx_output_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // stimulus, reset and end of run
    initial begin : stim_proc
        logic [7:0] body[$];
        logic [7:0] seq;
        logic [7:0] last_seq;
        int         kind;
        int         n;
        int         directed_bytes;
        bit         long_done;

        clear_frame_state();
        prev_seq_r  = 8'hFF;
        msg_count_r = '0;

        // last frame reusing the reset sequence value: duplicate
        body.delete();
        body.push_back(FLAG_LAST);
        body.push_back(8'hFF);
        body.push_back(8'h00);
        queue_datagram(body, 1'b0);
        // one-byte frames: all-ones sums good, all-zero sums bad
        datagram_q.push_back('{data: 8'hFF, fin: 1'b1});
        datagram_q.push_back('{data: 8'h00, fin: 1'b1});
        frames_sent += 2;
        // non-last frame, final payload byte is summed but not passed
        body.delete();
        body.push_back(8'h00);
        body.push_back(8'h01);
        body.push_back(8'h00);
        body.push_back(8'hFF);
        body.push_back(8'h5A);
        queue_datagram(body, 1'b0);
        // last frame completing the message, then its retransmission
        body.delete();
        body.push_back(FLAG_LAST);
        body.push_back(8'h02);
        body.push_back(8'h03);
        body.push_back(8'hFF);
        body.push_back(8'h80);
        body.push_back(8'h01);
        queue_datagram(body, 1'b0);
        queue_datagram(body, 1'b0);
        directed_bytes = datagram_q.size();

        // random frames: mostly well formed, some corrupt, truncated or noise
        last_seq  = 8'h02;
        long_done = 1'b0;
        while (datagram_q.size() < directed_bytes + RANDOM_BYTES) begin
            n = $urandom_range(0, 9);
            if (n < 2) begin
                seq = last_seq;
            end else if (n < 8) begin
                seq = last_seq + 8'd1;
            end else begin
                seq = 8'($urandom_range(0, 255));
            end
            body.delete();
            kind = $urandom_range(0, 99);
            if (!long_done && datagram_q.size() > directed_bytes + LONG_AFTER) begin
                // oversize frame: full payload, trailer byte and ignored bytes
                long_done = 1'b1;
                body.push_back(8'h00);
                body.push_back(seq);
                for (int i = 0; i < FRAME_LEN + 1; i++) begin
                    body.push_back(8'($urandom_range(0, 255)));
                end
                queue_datagram(body, 1'b0);
                last_seq = seq;
            end else if (kind < 45) begin
                // last frame with length byte
                n = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255)
                                                 : $urandom_range(0, 12);
                body.push_back(FLAG_LAST);
                body.push_back(seq);
                body.push_back(8'(n));
                for (int i = 0; i < n; i++) begin
                    body.push_back(8'($urandom_range(0, 255)));
                end
                if ($urandom_range(0, 9) == 0) begin
                    repeat ($urandom_range(1, 3)) body.push_back(8'($urandom_range(0, 255)));
                end else if ($urandom_range(0, 9) == 0) begin
                    repeat ($urandom_range(1, body.size())) void'(body.pop_back());
                end
                queue_datagram(body, $urandom_range(0, 9) == 0);
                last_seq = seq;
            end else if (kind < 85) begin
                // short non-last frame
                body.push_back(8'($urandom_range(0, 255)));
                if (body[0] == FLAG_LAST) begin
                    body[0] = 8'h00;
                end
                body.push_back(seq);
                n = $urandom_range(0, 16);
                for (int i = 0; i < n; i++) begin
                    body.push_back(8'($urandom_range(0, 255)));
                end
                queue_datagram(body, $urandom_range(0, 9) == 0);
                last_seq = seq;
            end else begin
                // noise datagram
                n = $urandom_range(1, 12);
                for (int i = 0; i < n; i++) begin
                    datagram_q.push_back('{data: 8'($urandom_range(0, 255)),
                                           fin: (i == n - 1)});
                end
                frames_sent++;
            end
        end
        bytes_total = datagram_q.size();

        // reset
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // drain
        while (bytes_accepted < bytes_total) @(posedge aclk);
        while (rx_output_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("sent %0d datagrams in %0d bytes; %0d payload bytes passed through",
                 frames_sent, bytes_total, payload_seen);
        $display("verdicts: %0d accepted, %0d duplicate, %0d bad checksum",
                 accept_seen, dup_seen, bad_seen);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/swfr_pkg.sv
rtl/swfr_frame.sv
rtl/stop_and_wait_frame_receiver.sv
tb/tb_top.sv
